// File: src/msar_pkg.sv
// Shared types, constants and helpers for the mid-side allpass reverb.
`default_nettype none
package msar_pkg;
    localparam int STAGES      = 8;
    localparam int CHAINS      = 2;
    localparam int MAX_DELAY   = 8192;
    localparam int SAMPLE_BITS = 24;
    localparam int REG_COUNT   = 8;
    localparam int SLOTS       = CHAINS * STAGES;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int POS_BITS    = $clog2(MAX_DELAY);
    localparam int ADDR_BITS   = SLOT_BITS + POS_BITS;
    localparam int DEPTH       = SLOTS * MAX_DELAY;
    localparam int STAGE_BITS  = $clog2(STAGES);
    localparam int PADDR_BITS  = 6;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam logic signed [SAMPLE_BITS+1:0] SMAX =
        {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS+1:0] SMIN =
        {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_READ, ST_MUL1, ST_MUL2, ST_OUT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read;
        logic mul1;
        logic mul2;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic last_slot;
    } t_status;

    function automatic t_sample sat(input logic signed [SAMPLE_BITS+1:0] v);
        if (v > SMAX) return SMAX[SAMPLE_BITS-1:0];
        if (v < SMIN) return SMIN[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// File: src/msar_stream_if.sv
// Valid/ready stream interface carrying input and result items.
`default_nettype none
interface msar_in_if;
    logic valid;
    logic ready;
    msar_pkg::t_sample in_sample;
    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface msar_out_if;
    logic valid;
    logic ready;
    msar_pkg::t_sample out_sum;
    msar_pkg::t_sample out_diff;
    modport source (output valid, output out_sum, output out_diff, input ready);
    modport sink   (input valid, input out_sum, input out_diff, output ready);
endinterface
`default_nettype wire

// File: src/mid_side_allpass_reverb_unit.sv
// Top level of the mid-side allpass reverb: APB registers, controller, datapath.
// Each item runs through fetch, read and two multiply steps for each of the 16 stages, the
// first fetch taken in the idle state, and then an emit step.
// The next item is not accepted until the result is taken.
// Reset clears registers and positions, then a clearing pass zeroes the delay
// memory; no item is accepted until it ends.
`default_nettype none
module mid_side_allpass_reverb_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    msar_in_if.sink          i_in,
    msar_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [msar_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [63:0] r_regs [msar_pkg::REG_COUNT];
    msar_pkg::t_cmd cmd;
    msar_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msar_pkg::REG_COUNT; i++) r_regs[i] <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_regs[paddr[5:3]] <= pwdata;
        end
    end
    assign prdata = r_regs[paddr[5:3]];
    assign pready = 1'b1;

    msar_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid), .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_status(status), .o_cmd(cmd)
    );

    msar_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_sample(i_in.in_sample),
        .i_regs(r_regs), .o_status(status),
        .o_sum(o_out.out_sum), .o_diff(o_out.out_diff)
    );
endmodule
`default_nettype wire

// File: src/msar_ctrl.sv
// Sequencer for clearing, per-stage steps and result hand-off.
`default_nettype none
module msar_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire msar_pkg::t_status i_status,
    output msar_pkg::t_cmd       o_cmd
);
    msar_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msar_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            msar_pkg::ST_CLEAR: if (i_status.clear_done) n_state = msar_pkg::ST_IDLE;
            msar_pkg::ST_IDLE:  if (i_in_valid && !r_out_valid) n_state = msar_pkg::ST_READ;
            msar_pkg::ST_FETCH: n_state = msar_pkg::ST_READ;
            msar_pkg::ST_READ:  n_state = msar_pkg::ST_MUL1;
            msar_pkg::ST_MUL1:  n_state = msar_pkg::ST_MUL2;
            msar_pkg::ST_MUL2: begin
                if (i_status.last_slot) n_state = msar_pkg::ST_OUT;
                else n_state = msar_pkg::ST_FETCH;
            end
            msar_pkg::ST_OUT:   n_state = msar_pkg::ST_IDLE;
            default:            n_state = msar_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            msar_pkg::ST_CLEAR: o_cmd.clear_step = 1'b1;
            msar_pkg::ST_IDLE: begin
                o_in_ready = !r_out_valid;
                o_cmd.load = i_in_valid && !r_out_valid;
            end
            msar_pkg::ST_READ: o_cmd.read = 1'b1;
            msar_pkg::ST_MUL1: o_cmd.mul1 = 1'b1;
            msar_pkg::ST_MUL2: o_cmd.mul2 = 1'b1;
            msar_pkg::ST_OUT: begin
                o_cmd.emit = 1'b1;
                n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// File: src/msar_datapath.sv
// Delay memory, stage arithmetic, positions and output registers.
`default_nettype none
module msar_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire msar_pkg::t_cmd    i_cmd,
    input  wire msar_pkg::t_sample i_sample,
    input  wire logic [63:0]       i_regs [msar_pkg::REG_COUNT],
    output msar_pkg::t_status      o_status,
    output msar_pkg::t_sample      o_sum,
    output msar_pkg::t_sample      o_diff
);
    localparam int SB = msar_pkg::SAMPLE_BITS;

    msar_pkg::t_sample r_mem [msar_pkg::DEPTH];
    logic [msar_pkg::ADDR_BITS:0]   r_clr;
    logic [msar_pkg::SLOT_BITS-1:0] r_slot;
    logic [msar_pkg::POS_BITS-1:0]  r_pos [msar_pkg::SLOTS];
    msar_pkg::t_sample r_x, r_b, r_a, r_mid, r_sum, r_diff, r_rd;
    logic signed [SB+17:0] r_prod;
    msar_pkg::t_sample r_sample_hold;
    logic signed [SB+17:0] r_prod2;

    logic chain;
    logic [msar_pkg::STAGE_BITS-1:0] stage;
    logic [15:0] len_raw, coef;
    logic [16:0] len;
    logic [msar_pkg::POS_BITS-1:0] pos, pos_next;
    logic [msar_pkg::ADDR_BITS-1:0] addr;
    logic signed [SB+17:0] prod;
    logic signed [SB+1:0] rnd, diff_w;
    logic signed [SB+1:0] rnd2, sum_w2;
    msar_pkg::t_sample a_new, y_new;

    assign chain = r_slot[msar_pkg::SLOT_BITS-1];
    assign stage = r_slot[msar_pkg::STAGE_BITS-1:0];

    always_comb begin
        len_raw = 16'd1;
        coef    = 16'd0;
        if (int'(stage) < 8) begin
            len_raw = 16'(i_regs[{1'b0, chain, stage[2]}] >> (16 * stage[1:0]));
            coef    = 16'(i_regs[{1'b1, chain, stage[2]}] >> (16 * stage[1:0]));
        end
        len = (len_raw == 16'd0) ? 17'd1 : {1'b0, len_raw};
        if (len > 17'(msar_pkg::MAX_DELAY)) len = 17'(msar_pkg::MAX_DELAY);
    end

    assign pos = r_pos[r_slot];
    assign addr = {r_slot, pos};
    assign pos_next = (17'(pos) + 17'd1 >= len) ? '0 : pos + 1'b1;
    assign prod = (i_cmd.read ? $signed({r_rd[SB-1], r_rd}) : $signed({r_a[SB-1], r_a}))
                  * $signed({1'b0, coef});
    assign rnd = (SB+2)'((r_prod + 32768) >>> 16);
    assign a_new = msar_pkg::sat($signed({{2{r_x[SB-1]}}, r_x}) + rnd);
    assign y_new = msar_pkg::sat($signed({{2{r_b[SB-1]}}, r_b}) - rnd2);
    assign diff_w = ($signed({{2{r_mid[SB-1]}}, r_mid}) - $signed({{2{r_x[SB-1]}}, r_x})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr[msar_pkg::ADDR_BITS-1:0]] <= '0;
        end else if (i_cmd.mul2) begin
            r_mem[addr] <= r_a;
        end
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_slot <= '0;
            for (int i = 0; i < msar_pkg::SLOTS; i++) r_pos[i] <= '0;
        end else begin
            if (i_cmd.clear_step && !r_clr[msar_pkg::ADDR_BITS]) r_clr <= r_clr + 1'b1;
            if (i_cmd.mul2) begin
                r_pos[r_slot] <= pos_next;
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // read: memory word is in r_rd, first product registered; mul1: new a registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_x <= i_sample;
        if (i_cmd.read) begin
            r_b    <= r_rd;
            r_prod <= prod;
        end
        if (i_cmd.mul1) begin
            r_a    <= a_new;
        end
        if (i_cmd.mul2) begin
            if (r_slot == msar_pkg::SLOT_BITS'(msar_pkg::STAGES - 1)) begin
                r_mid <= y_new;
                r_x   <= r_sample_hold;
            end else begin
                r_x <= y_new;
            end
        end
        if (i_cmd.emit) begin
            r_sum  <= msar_pkg::sat(sum_w2);
            r_diff <= msar_pkg::sat(diff_w);
        end
    end

    // second product: a*k, registered separately
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample_hold <= i_sample;
        if (i_cmd.mul1) r_prod2 <= $signed({a_new[SB-1], a_new}) * $signed({1'b0, coef});
    end
    assign rnd2 = (SB+2)'((r_prod2 + 32768) >>> 16);
    assign sum_w2 = ($signed({{2{r_mid[SB-1]}}, r_mid}) + $signed({{2{r_x[SB-1]}}, r_x})) >>> 1;

    assign o_status.clear_done = r_clr[msar_pkg::ADDR_BITS];
    assign o_status.last_slot  = (r_slot == msar_pkg::SLOT_BITS'(msar_pkg::SLOTS - 1));
    assign o_sum  = r_sum;
    assign o_diff = r_diff;
endmodule
`default_nettype wire
